// File: hdl/qtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtd_pkg
// Shared constants and types for the quadtree image decoder.
// ----------------------------------------------------------------------------
package qtd_pkg;

    // Largest supported image side, as log2 of the pixel count per row
    localparam int MAX_SIDE_LOG2_DEF = 10;

    // Fixed field widths of the transaction payloads
    localparam int SIDE_LOG2_W = 4;
    localparam int BYTE_W      = 8;
    localparam int COORD_W     = 10;
    localparam int SIDE_W      = 11;

    // Side register value after reset
    localparam logic [SIDE_LOG2_W-1:0] SIDE_LOG2_RESET = 4'd9;

    // Stream marker codes
    localparam logic [BYTE_W-1:0] MARK_SPLIT = 8'd0;
    localparam logic [BYTE_W-1:0] MARK_LEAF  = 8'd1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    // Per-command status flags
    typedef struct packed {
        logic bad;
        logic done;
    } qtd_flags_t;

endpackage

// File: hdl/qtd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtd_front
// Accepts stream bytes, tracks the Z-order cursor and level, and issues one
// fill command per leaf or bad node toward the command queue.
// ----------------------------------------------------------------------------
module qtd_front
    import qtd_pkg::*;
#(
    parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF,
    parameter int CW            = 2 * MAX_SIDE_LOG2,
    parameter int LW            = $clog2(MAX_SIDE_LOG2 + 1)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [SIDE_LOG2_W-1:0] cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      stream_byte,
    input  logic                   queue_full,
    output logic                   push,
    output logic [CW-1:0]          push_cursor,
    output logic [LW-1:0]          push_rem,
    output logic [BYTE_W-1:0]      push_gray,
    output qtd_flags_t             push_flags
);

    logic [SIDE_LOG2_W-1:0] side_log2_reg, side_log2_next;
    logic [CW-1:0]          cursor_reg, cursor_next;
    logic [LW-1:0]          level_reg, level_next;
    logic                   expect_gray_reg, expect_gray_next;
    logic                   finished_reg, finished_next;

    logic          accept;
    logic [LW-1:0] eff_log2;
    logic [LW-1:0] rem;
    logic [CW-1:0] cursor_sum;
    logic [LW-1:0] level_after;
    logic          emit;
    logic          emit_bad;
    logic          go_down;
    logic [1:0]    digit;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    // Clamp the configured side to the supported maximum
    assign eff_log2 = (int'(side_log2_reg) > MAX_SIDE_LOG2) ?
                      LW'(MAX_SIDE_LOG2) : LW'(side_log2_reg);
    assign rem = eff_log2 - level_reg;

    // Step the cursor past the current node
    assign cursor_sum = cursor_reg + (CW'(1) << {rem, 1'b0});

    // Pop levels: new level comes from the lowest nonzero digit below the root
    always_comb
    begin
        level_after = '0;
        digit       = 2'b00;
        for (int d = MAX_SIDE_LOG2 - 1; d >= 0; d--)
        begin
            digit = cursor_sum[2*d +: 2];
            if ((LW'(d) < eff_log2) && (digit != 2'b00))
            begin
                level_after = eff_log2 - LW'(d);
            end
        end
    end

    // Classify the byte
    always_comb
    begin
        emit     = 1'b0;
        emit_bad = 1'b0;
        go_down  = 1'b0;
        if (!finished_reg)
        begin
            if (expect_gray_reg)
            begin
                emit = 1'b1;
            end
            else if (stream_byte == MARK_LEAF)
            begin
                emit = 1'b0;
            end
            else if ((stream_byte == MARK_SPLIT) && (level_reg < eff_log2))
            begin
                go_down = 1'b1;
            end
            else
            begin
                emit     = 1'b1;
                emit_bad = 1'b1;
            end
        end
    end

    // Command toward the queue
    assign push            = accept && emit;
    assign push_cursor     = cursor_reg;
    assign push_rem        = rem;
    assign push_gray       = emit_bad ? '0 : stream_byte;
    assign push_flags.bad  = emit_bad;
    assign push_flags.done = (level_after == '0);

    // Next state: restart on a register write, advance on an accepted byte
    always_comb
    begin
        side_log2_next   = side_log2_reg;
        cursor_next      = cursor_reg;
        level_next       = level_reg;
        expect_gray_next = expect_gray_reg;
        finished_next    = finished_reg;
        if (cfg_we)
        begin
            side_log2_next   = cfg_wdata;
            cursor_next      = '0;
            level_next       = '0;
            expect_gray_next = 1'b0;
            finished_next    = 1'b0;
        end
        else if (accept && !finished_reg)
        begin
            if (emit)
            begin
                expect_gray_next = 1'b0;
                cursor_next      = cursor_sum;
                level_next       = level_after;
                finished_next    = (level_after == '0);
            end
            else if (go_down)
            begin
                level_next = level_reg + LW'(1);
            end
            else
            begin
                expect_gray_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_log2_reg   <= SIDE_LOG2_RESET;
            cursor_reg      <= '0;
            level_reg       <= '0;
            expect_gray_reg <= 1'b0;
            finished_reg    <= 1'b0;
        end
        else
        begin
            side_log2_reg   <= side_log2_next;
            cursor_reg      <= cursor_next;
            level_reg       <= level_next;
            expect_gray_reg <= expect_gray_next;
            finished_reg    <= finished_next;
        end
    end

endmodule

// File: hdl/qtd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtd_queue
// Short register queue holding fill commands between front and back.
// ----------------------------------------------------------------------------
module qtd_queue
    import qtd_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);

    logic [WIDTH-1:0]    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_data = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/qtd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtd_back
// Turns queued commands into fill transactions: splits the Z-order cursor
// into x and y, expands the side, and holds the result in an output register.
// ----------------------------------------------------------------------------
module qtd_back
    import qtd_pkg::*;
#(
    parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF,
    parameter int CW            = 2 * MAX_SIDE_LOG2,
    parameter int LW            = $clog2(MAX_SIDE_LOG2 + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               queue_empty,
    output logic               pop,
    input  logic [CW-1:0]      head_cursor,
    input  logic [LW-1:0]      head_rem,
    input  logic [BYTE_W-1:0]  head_gray,
    input  qtd_flags_t         head_flags,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COORD_W-1:0] fill_x,
    output logic [COORD_W-1:0] fill_y,
    output logic [SIDE_W-1:0]  fill_side,
    output logic [BYTE_W-1:0]  gray,
    output logic               bad_node,
    output logic               tree_done
);

    logic                      out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]        x_reg, y_reg;
    logic [SIDE_W-1:0]         side_reg;
    logic [BYTE_W-1:0]         gray_reg;
    qtd_flags_t                flags_reg;

    logic [CW+2*COORD_W-1:0]   cursor_pad;
    logic [COORD_W-1:0]        x_calc, y_calc;
    logic [SIDE_W-1:0]         side_calc;

    // Load the output register when it is free or being taken
    assign pop = !queue_empty && (!out_valid_reg || !out_stall);

    // Take x from even cursor bits, y from odd ones
    assign cursor_pad = {{(2*COORD_W){1'b0}}, head_cursor};
    always_comb
    begin
        for (int i = 0; i < COORD_W; i++)
        begin
            x_calc[i] = cursor_pad[2*i];
            y_calc[i] = cursor_pad[2*i+1];
        end
    end

    // Side is one bit at position rem, dropped beyond the field width
    always_comb
    begin
        for (int i = 0; i < SIDE_W; i++)
        begin
            side_calc[i] = (int'(head_rem) == i);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            x_reg     <= x_calc;
            y_reg     <= y_calc;
            side_reg  <= side_calc;
            gray_reg  <= head_gray;
            flags_reg <= head_flags;
        end
    end

    assign out_valid = out_valid_reg;
    assign fill_x    = x_reg;
    assign fill_y    = y_reg;
    assign fill_side = side_reg;
    assign gray      = gray_reg;
    assign bad_node  = flags_reg.bad;
    assign tree_done = flags_reg.done;

endmodule

// File: hdl/quadtree_image_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadtree_image_decoder
// Decodes a preorder quadtree byte stream into square fill transactions.
//
//   Channel  Signals                                        Direction
//   config   cfg_we, cfg_wdata[3:0] (side_log2)             in, write only
//   input    in_valid, in_stall, stream_byte[7:0]           in
//   output   out_valid, out_stall, fill_x, fill_y,          out
//            fill_side, gray, bad_node, tree_done
//
// One byte is accepted per cycle while in_stall is low; a fill for an accepted
// byte passes through the command queue and then the output register. The front
// tracks the Z-order cursor and level; a two-entry command queue feeds the back,
// so in_stall rises only when that queue is full under a stalled output. Reset
// is asynchronous and sets side_log2 to 9; a config write restarts decoding.
// ----------------------------------------------------------------------------
module quadtree_image_decoder
    import qtd_pkg::*;
#(
    parameter int MAX_SIDE_LOG2 = MAX_SIDE_LOG2_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [SIDE_LOG2_W-1:0] cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      stream_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COORD_W-1:0]     fill_x,
    output logic [COORD_W-1:0]     fill_y,
    output logic [SIDE_W-1:0]      fill_side,
    output logic [BYTE_W-1:0]      gray,
    output logic                   bad_node,
    output logic                   tree_done
);

    localparam int CW = 2 * MAX_SIDE_LOG2;
    localparam int LW = $clog2(MAX_SIDE_LOG2 + 1);
    localparam int QW = CW + LW + BYTE_W + $bits(qtd_flags_t);

    logic              push;
    logic [CW-1:0]     push_cursor;
    logic [LW-1:0]     push_rem;
    logic [BYTE_W-1:0] push_gray;
    qtd_flags_t        push_flags;

    logic              pop;
    logic              queue_empty;
    logic              queue_full;
    logic [QW-1:0]     head_data;
    logic [CW-1:0]     head_cursor;
    logic [LW-1:0]     head_rem;
    logic [BYTE_W-1:0] head_gray;
    qtd_flags_t        head_flags;

    qtd_front #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2),
        .CW            (CW),
        .LW            (LW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stream_byte (stream_byte),
        .queue_full  (queue_full),
        .push        (push),
        .push_cursor (push_cursor),
        .push_rem    (push_rem),
        .push_gray   (push_gray),
        .push_flags  (push_flags)
    );

    qtd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_cursor, push_rem, push_gray, push_flags}),
        .pop       (pop),
        .head_data (head_data),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    assign {head_cursor, head_rem, head_gray, head_flags} = head_data;

    qtd_back #(
        .MAX_SIDE_LOG2 (MAX_SIDE_LOG2),
        .CW            (CW),
        .LW            (LW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop         (pop),
        .head_cursor (head_cursor),
        .head_rem    (head_rem),
        .head_gray   (head_gray),
        .head_flags  (head_flags),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fill_x      (fill_x),
        .fill_y      (fill_y),
        .fill_side   (fill_side),
        .gray        (gray),
        .bad_node    (bad_node),
        .tree_done   (tree_done)
    );

endmodule

// File: verif/quadtree_image_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadtree_image_decoder_tb
// Drives preorder quadtree byte streams into the decoder and checks every fill
// against the row's expected fill or a Z-order cursor model kept in the bench.
// A short table of directed streams covers the image size limits and bad nodes;
// random trees follow under changing sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module quadtree_image_decoder_tb;
    import qtd_pkg::*;

    localparam int MAX_LOG2     = MAX_SIDE_LOG2_DEF;
    localparam int RANDOM_BYTES = 850;
    localparam int SETTLE_CYC   = 8;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIDE_W-1:0]  side;
        logic [BYTE_W-1:0]  gray;
        logic               bad;
        logic               done;
    } fill_t;

    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [BYTE_W-1:0] value;
        logic              typed;
        fill_t             fill;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [SIDE_LOG2_W-1:0] cfg_wdata;
    logic                   in_valid;
    logic                   in_stall;
    logic [BYTE_W-1:0]      stream_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic [COORD_W-1:0]     fill_x;
    logic [COORD_W-1:0]     fill_y;
    logic [SIDE_W-1:0]      fill_side;
    logic [BYTE_W-1:0]      gray;
    logic                   bad_node;
    logic                   tree_done;

    // Decoder model state
    logic [SIDE_LOG2_W-1:0] side_reg;
    logic [31:0]            zcursor;
    logic [3:0]             depth;
    logic                   gray_next;
    logic                   image_done;

    fill_t     fills_pending[$];
    stim_row_t stim_table[$];
    int        error_count;
    int        bytes_fed;
    int        in_idle_pct;
    int        out_stall_pct;

    quadtree_image_decoder #(
        .MAX_SIDE_LOG2 (MAX_LOG2)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stream_byte (stream_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fill_x      (fill_x),
        .fill_y      (fill_y),
        .fill_side   (fill_side),
        .gray        (gray),
        .bad_node    (bad_node),
        .tree_done   (tree_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop for a hung handshake
    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int eff_log2();
        return (side_reg > MAX_LOG2) ? MAX_LOG2 : int'(side_reg);
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Advance the model by one accepted byte; flag a fill when one is due
    task automatic decode_byte(input logic [BYTE_W-1:0] b, output logic got,
                               output fill_t res);
        int unsigned eff;
        int unsigned rem;
        int          i;
        logic        emit;
        logic        bad;
        logic [BYTE_W-1:0] g;
        begin
            got  = 1'b0;
            res  = '0;
            emit = 1'b0;
            bad  = 1'b0;
            g    = '0;
            eff  = eff_log2();
            if (image_done)
                emit = 1'b0;
            else if (gray_next)
            begin
                gray_next = 1'b0;
                emit      = 1'b1;
                g         = b;
            end
            else if (b == MARK_LEAF)
                gray_next = 1'b1;
            else if (b == MARK_SPLIT && depth < eff)
                depth = depth + 1'b1;
            else
            begin
                emit = 1'b1;
                bad  = 1'b1;
            end
            if (emit)
            begin
                rem = eff - depth;
                for (i = 0; i < COORD_W; i++)
                begin
                    res.x[i] = zcursor[2*i];
                    res.y[i] = zcursor[2*i+1];
                end
                res.side[rem] = 1'b1;
                res.gray      = g;
                res.bad       = bad;
                // Step to the next node in Z order, climbing out of finished quadrants
                zcursor = zcursor + (32'd1 << (2 * rem));
                while (depth > 0 && ((zcursor >> (2 * (eff - depth))) & 32'd3) == 0)
                    depth = depth - 1'b1;
                res.done = (depth == 0);
                if (depth == 0)
                    image_done = 1'b1;
                got = 1'b1;
            end
        end
    endtask

    task automatic add_cfg(input int v);
        stim_row_t row;
        begin
            row       = '0;
            row.kind  = ROW_CFG;
            row.value = BYTE_W'(v);
            stim_table.push_back(row);
        end
    endtask

    task automatic add_byte(input int b);
        stim_row_t row;
        begin
            row       = '0;
            row.kind  = ROW_BYTE;
            row.value = BYTE_W'(b);
            stim_table.push_back(row);
        end
    endtask

    task automatic add_fill(input int b, input int x, input int y, input int side,
                            input int g, input logic bad, input logic done);
        stim_row_t row;
        begin
            row           = '0;
            row.kind      = ROW_BYTE;
            row.value     = BYTE_W'(b);
            row.typed     = 1'b1;
            row.fill.x    = COORD_W'(x);
            row.fill.y    = COORD_W'(y);
            row.fill.side = SIDE_W'(side);
            row.fill.gray = BYTE_W'(g);
            row.fill.bad  = bad;
            row.fill.done = done;
            stim_table.push_back(row);
        end
    endtask

    // Present one byte, hold it until accepted, then record what it should cause
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                             input fill_t typed_fill);
        logic  got;
        logic  was_done;
        fill_t res;
        begin
            @(negedge clk);
            while ($urandom_range(0, 99) < in_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid    <= 1'b1;
            stream_byte <= b;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            was_done = image_done;
            decode_byte(b, got, res);
            if (typed)
                fills_pending.push_back(typed_fill);
            else if (got)
                fills_pending.push_back(res);
            if (!was_done)
                bytes_fed++;
        end
    endtask

    // Drop valid and wait until the decoder has drained
    task automatic settle();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (fills_pending.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYC) @(posedge clk);
        end
    endtask

    task automatic write_side(input logic [SIDE_LOG2_W-1:0] v);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= v;
            @(negedge clk);
            cfg_we     <= 1'b0;
            side_reg   = v;
            zcursor    = '0;
            depth      = '0;
            gray_next  = 1'b0;
            image_done = 1'b0;
        end
    endtask

    // Receiver stall, redrawn every cycle
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < out_stall_pct);

    // Check each accepted fill against the oldest expectation
    always @(posedge clk)
    begin
        fill_t got_fill;
        fill_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got_fill.x    = fill_x;
            got_fill.y    = fill_y;
            got_fill.side = fill_side;
            got_fill.gray = gray;
            got_fill.bad  = bad_node;
            got_fill.done = tree_done;
            if (fills_pending.size() == 0)
                note_error($sformatf("unexpected fill x=%0d y=%0d side=%0d gray=%0d bad=%0b done=%0b",
                           fill_x, fill_y, fill_side, gray, bad_node, tree_done));
            else
            begin
                want = fills_pending.pop_front();
                if (want !== got_fill)
                    note_error($sformatf({"fill mismatch: exp x=%0d y=%0d side=%0d gray=%0d ",
                               "bad=%0b done=%0b, got x=%0d y=%0d side=%0d gray=%0d bad=%0b done=%0b"},
                               want.x, want.y, want.side, want.gray, want.bad, want.done,
                               fill_x, fill_y, fill_side, gray, bad_node, tree_done));
            end
        end
    end

    initial
    begin
        int                     i;
        int                     r;
        int                     eff;
        int                     tree_len;
        int                     abort_at;
        int                     drain;
        logic [BYTE_W-1:0]      b;
        logic [SIDE_LOG2_W-1:0] new_side;

        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        stream_byte   = '0;
        out_stall     = 1'b0;
        error_count   = 0;
        bytes_fed     = 0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        side_reg      = SIDE_LOG2_RESET;
        zcursor       = '0;
        depth         = '0;
        gray_next     = 1'b0;
        image_done    = 1'b0;

        // Directed streams: root leaf after reset, bytes past the end,
        // one-pixel image, split at side one, invalid markers, oversize side
        add_byte(MARK_LEAF);
        add_fill(8'hAB, 0, 0, 512, 8'hAB, 1'b0, 1'b1);
        add_byte(8'h55);
        add_cfg(0);
        add_byte(MARK_LEAF);
        add_fill(8'hFF, 0, 0, 1, 8'hFF, 1'b0, 1'b1);
        add_cfg(0);
        add_fill(MARK_SPLIT, 0, 0, 1, 0, 1'b1, 1'b1);
        add_cfg(1);
        add_byte(MARK_SPLIT);
        add_byte(MARK_LEAF);
        add_fill(8'h00, 0, 0, 1, 0, 1'b0, 1'b0);
        add_fill(8'h02, 1, 0, 1, 0, 1'b1, 1'b0);
        add_fill(8'hFF, 0, 1, 1, 0, 1'b1, 1'b0);
        add_fill(MARK_SPLIT, 1, 1, 1, 0, 1'b1, 1'b1);
        add_cfg(15);
        add_fill(8'h7F, 0, 0, 1024, 0, 1'b1, 1'b1);
        add_cfg(10);
        add_byte(MARK_SPLIT);
        add_byte(MARK_LEAF);
        add_byte(8'h80);
        add_byte(MARK_SPLIT);
        add_byte(MARK_SPLIT);
        add_byte(8'hFE);
        add_byte(MARK_LEAF);
        add_byte(8'h3C);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < stim_table.size(); i++)
        begin
            if (stim_table[i].kind == ROW_CFG)
            begin
                settle();
                write_side(stim_table[i].value[SIDE_LOG2_W-1:0]);
            end
            else
                send_byte(stim_table[i].value, stim_table[i].typed, stim_table[i].fill);
        end
        bytes_fed = 0;

        // Random trees, one per side setting, rotating through the idling phases
        while (bytes_fed < RANDOM_BYTES)
        begin
            settle();
            case ((bytes_fed / 110) % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 77; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 77; end
                default: begin in_idle_pct = 10; out_stall_pct = 10; end
            endcase
            r = $urandom_range(0, 19);
            if (r == 0)
                new_side = SIDE_LOG2_W'($urandom_range(10, 15));
            else if (r == 1)
                new_side = '0;
            else
                new_side = SIDE_LOG2_W'($urandom_range(0, 5));
            write_side(new_side);

            // Abort a few trees midway to restart from a fresh write
            tree_len = 0;
            abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 100000;
            while (!image_done && tree_len < abort_at)
            begin
                eff = eff_log2();
                r   = $urandom_range(0, 99);
                if (gray_next)
                    b = BYTE_W'($urandom_range(0, 255));
                else if (r < 8)
                    b = BYTE_W'($urandom_range(2, 255));
                else if (depth < eff && tree_len < 150 && r < ((depth < 2) ? 65 : 30))
                    b = MARK_SPLIT;
                else if (depth == eff && r < 14)
                    b = MARK_SPLIT;
                else
                    b = MARK_LEAF;
                send_byte(b, 1'b0, '0);
                tree_len++;
            end
            // Trailing bytes after a finished image should be dropped
            if (image_done)
                repeat ($urandom_range(0, 2))
                    send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        for (drain = 0; drain < 5000 && fills_pending.size() != 0; drain++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fills_pending.size() != 0)
            note_error($sformatf("%0d fills never arrived", fills_pending.size()));

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: quadtree_image_decoder.f
hdl/qtd_pkg.sv
hdl/qtd_front.sv
hdl/qtd_queue.sv
hdl/qtd_back.sv
hdl/quadtree_image_decoder.sv
verif/quadtree_image_decoder_tb.sv
